[hw/rtl/emp_pkg.sv]
// shared types and constants for the energy density and poynting vector core
package emp_pkg;

  // field widths
  localparam int IN_W   = 32;
  localparam int OUT_W  = 48;
  localparam int CFG_W  = 32;
  localparam int PROD_W = 2 * IN_W;
  // energy sum of two 32x64 products
  localparam int TOT_W  = CFG_W + PROD_W + 1;
  // flux magnitude times reciprocal permeability
  localparam int MAG_W  = CFG_W + PROD_W;
  // sum of three squared 48 bit magnitudes
  localparam int SQ_W   = 2 * OUT_W + 2;
  // root of a SQ_W bit value
  localparam int ROOT_W = SQ_W / 2;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
  localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

  // configuration register indexes
  localparam logic CFG_PERMITTIVITY = 1'b0;
  localparam logic CFG_INV_PERM     = 1'b1;

  // results that ride along the root chain
  typedef struct packed {
    logic [OUT_W-1:0]        energy;
    logic signed [OUT_W-1:0] flux_x;
    logic signed [OUT_W-1:0] flux_y;
    logic signed [OUT_W-1:0] flux_z;
    logic                    huge;
    logic                    sat;
  } side_t;

  // contents of one root cell
  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
    side_t             side;
  } cell_t;

endpackage

[hw/rtl/emp_front.sv]
// multiply, cross product, scaling and saturation stages ahead of the root chain
module emp_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [emp_pkg::CFG_W-1:0]         permittivity,
  input  logic [emp_pkg::CFG_W-1:0]         inv_perm,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic signed [emp_pkg::IN_W-1:0]   e_x,
  input  logic signed [emp_pkg::IN_W-1:0]   e_y,
  input  logic signed [emp_pkg::IN_W-1:0]   e_z,
  input  logic signed [emp_pkg::IN_W-1:0]   b_x,
  input  logic signed [emp_pkg::IN_W-1:0]   b_y,
  input  logic signed [emp_pkg::IN_W-1:0]   b_z,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output emp_pkg::cell_t                    dn_data
);

  localparam int NST    = 8;
  localparam int IN_W   = emp_pkg::IN_W;
  localparam int OUT_W  = emp_pkg::OUT_W;
  localparam int PROD_W = emp_pkg::PROD_W;
  localparam int CFG_W  = emp_pkg::CFG_W;
  localparam int TOT_W  = emp_pkg::TOT_W;
  localparam int MAG_W  = emp_pkg::MAG_W;
  localparam int SQ_W   = emp_pkg::SQ_W;
  localparam int HALF_W = IN_W;
  localparam int TOP_W  = OUT_W - HALF_W;
  localparam int EN_SH  = 2 * FRAC_BITS + 1;
  localparam int MG_SH  = 2 * FRAC_BITS;

  // stage handshake
  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = dn_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 1: squares and cross product terms
  logic signed [PROD_W-1:0] sqe_r [3];
  logic signed [PROD_W-1:0] sqb_r [3];
  logic signed [PROD_W-1:0] cpa_r [3];
  logic signed [PROD_W-1:0] cpb_r [3];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sqe_r[0] <= e_x * e_x;
      sqe_r[1] <= e_y * e_y;
      sqe_r[2] <= e_z * e_z;
      sqb_r[0] <= b_x * b_x;
      sqb_r[1] <= b_y * b_y;
      sqb_r[2] <= b_z * b_z;
      cpa_r[0] <= e_y * b_z;
      cpb_r[0] <= e_z * b_y;
      cpa_r[1] <= e_z * b_x;
      cpb_r[1] <= e_x * b_z;
      cpa_r[2] <= e_x * b_y;
      cpb_r[2] <= e_y * b_x;
    end
  end

  // stage 2: squared norms and cross product magnitudes
  logic [PROD_W-1:0] ee_r;
  logic [PROD_W-1:0] bb_r;
  logic [PROD_W-1:0] mag_r [3];
  logic [2:0]        neg2_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ee_r <= PROD_W'(sqe_r[0]) + PROD_W'(sqe_r[1]) + PROD_W'(sqe_r[2]);
      bb_r <= PROD_W'(sqb_r[0]) + PROD_W'(sqb_r[1]) + PROD_W'(sqb_r[2]);
      for (int k = 0; k < 3; k++) begin
        logic [PROD_W-1:0] c;
        c = PROD_W'(cpa_r[k] - cpb_r[k]);
        neg2_r[k] <= c[PROD_W-1];
        mag_r[k]  <= c[PROD_W-1] ? (~c + PROD_W'(1)) : c;
      end
    end
  end

  // stage 3: partial products with the configuration scales
  logic [PROD_W-1:0] pe_lo_r, pe_hi_r, pb_lo_r, pb_hi_r;
  logic [PROD_W-1:0] pm_lo_r [3];
  logic [PROD_W-1:0] pm_hi_r [3];
  logic [2:0]        neg3_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      pe_lo_r <= PROD_W'(permittivity) * PROD_W'(ee_r[HALF_W-1:0]);
      pe_hi_r <= PROD_W'(permittivity) * PROD_W'(ee_r[PROD_W-1:HALF_W]);
      pb_lo_r <= PROD_W'(inv_perm) * PROD_W'(bb_r[HALF_W-1:0]);
      pb_hi_r <= PROD_W'(inv_perm) * PROD_W'(bb_r[PROD_W-1:HALF_W]);
      for (int k = 0; k < 3; k++) begin
        pm_lo_r[k] <= PROD_W'(inv_perm) * PROD_W'(mag_r[k][HALF_W-1:0]);
        pm_hi_r[k] <= PROD_W'(inv_perm) * PROD_W'(mag_r[k][PROD_W-1:HALF_W]);
      end
      neg3_r <= neg2_r;
    end
  end

  // stage 4: full width sums of the partial products
  logic [TOT_W-1:0] tot_r;
  logic [MAG_W-1:0] mf_r [3];
  logic [2:0]       neg4_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      tot_r <= TOT_W'(pe_lo_r) + (TOT_W'(pe_hi_r) << HALF_W)
             + TOT_W'(pb_lo_r) + (TOT_W'(pb_hi_r) << HALF_W);
      for (int k = 0; k < 3; k++) begin
        mf_r[k] <= MAG_W'(pm_lo_r[k]) + (MAG_W'(pm_hi_r[k]) << HALF_W);
      end
      neg4_r <= neg3_r;
    end
  end

  // stage 5: scale down, saturate energy and flux
  logic [OUT_W-1:0] m48_r [3];
  emp_pkg::side_t   side5_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      logic [TOT_W-1:0] es;
      logic [MAG_W-1:0] ms;
      logic [OUT_W-1:0] clip;
      logic [OUT_W-1:0] flux [3];
      logic             over;
      logic             sat;
      logic             huge;
      es   = tot_r >> EN_SH;
      sat  = |es[TOT_W-1:OUT_W];
      huge = 1'b0;
      side5_r.energy <= sat ? emp_pkg::OUT_MAX : es[OUT_W-1:0];
      for (int k = 0; k < 3; k++) begin
        ms = mf_r[k] >> MG_SH;
        huge = huge | (|ms[MAG_W-1:OUT_W]);
        if (neg4_r[k]) begin
          over = (|ms[MAG_W-1:OUT_W]) || (ms[OUT_W-1] && (|ms[OUT_W-2:0]));
          clip = over ? emp_pkg::NEG_MAG : ms[OUT_W-1:0];
          flux[k] = ~clip + OUT_W'(1);
        end else begin
          over = |ms[MAG_W-1:OUT_W-1];
          clip = over ? emp_pkg::POS_MAX : ms[OUT_W-1:0];
          flux[k] = clip;
        end
        sat = sat | over;
        m48_r[k] <= ms[OUT_W-1:0];
      end
      side5_r.flux_x <= flux[0];
      side5_r.flux_y <= flux[1];
      side5_r.flux_z <= flux[2];
      side5_r.huge   <= huge;
      side5_r.sat    <= sat | huge;
    end
  end

  // stage 6: partial squares of the truncated flux magnitudes
  logic [2*TOP_W-1:0]        hh_r [3];
  logic [TOP_W+HALF_W-1:0]   hl_r [3];
  logic [2*HALF_W-1:0]       ll_r [3];
  emp_pkg::side_t            side6_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int k = 0; k < 3; k++) begin
        hh_r[k] <= (2*TOP_W)'(m48_r[k][OUT_W-1:HALF_W]) * (2*TOP_W)'(m48_r[k][OUT_W-1:HALF_W]);
        hl_r[k] <= (TOP_W+HALF_W)'(m48_r[k][OUT_W-1:HALF_W])
                 * (TOP_W+HALF_W)'(m48_r[k][HALF_W-1:0]);
        ll_r[k] <= (2*HALF_W)'(m48_r[k][HALF_W-1:0]) * (2*HALF_W)'(m48_r[k][HALF_W-1:0]);
      end
      side6_r <= side5_r;
    end
  end

  // stage 7: square of each magnitude
  logic [2*OUT_W-1:0] sqk_r [3];
  emp_pkg::side_t     side7_r;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int k = 0; k < 3; k++) begin
        sqk_r[k] <= ((2*OUT_W)'(hh_r[k]) << (2*HALF_W))
                  + ((2*OUT_W)'(hl_r[k]) << (HALF_W + 1))
                  + (2*OUT_W)'(ll_r[k]);
      end
      side7_r <= side6_r;
    end
  end

  // stage 8: sum of squares, seeds the root chain
  emp_pkg::cell_t out_r;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      out_r.rem  <= SQ_W'(sqk_r[0]) + SQ_W'(sqk_r[1]) + SQ_W'(sqk_r[2]);
      out_r.root <= '0;
      out_r.side <= side7_r;
    end
  end

  assign dn_data = out_r;

endmodule

[hw/rtl/emp_sqrt_cell.sv]
// one cell of the root chain, settles one root bit per item
module emp_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  emp_pkg::cell_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output emp_pkg::cell_t dn_data
);

  localparam int SQ_W   = emp_pkg::SQ_W;
  localparam int ROOT_W = emp_pkg::ROOT_W;

  logic           valid_r;
  emp_pkg::cell_t data_r;
  emp_pkg::cell_t data_nxt;
  logic [SQ_W-1:0] trial;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // trial subtrahend 2*root*2^BIT + 4^BIT
  always_comb begin
    trial    = (SQ_W'(up_data.root) << (BIT + 1)) + (SQ_W'(1) << (2 * BIT));
    data_nxt = up_data;
    if (up_data.rem >= trial) begin
      data_nxt.rem  = up_data.rem - trial;
      data_nxt.root = up_data.root | (ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

[hw/rtl/em_energy_poynting_core.sv]
// top level: energy density, poynting vector and its norm per mesh node
// path: 8 arithmetic stages, 49 root cells and one output register from input accept
//   to result valid; results wait in place while the output is stalled
// throughput: one item per cycle while the output is not stalled; each root cell settles one bit of the norm
// stages hold items independently, so bubbles close up under backpressure
// reset: synchronous active low, clears all valid bits and sets both scales to 1.0
module em_energy_poynting_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [emp_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [emp_pkg::IN_W-1:0]   in_e_x,
  input  logic signed [emp_pkg::IN_W-1:0]   in_e_y,
  input  logic signed [emp_pkg::IN_W-1:0]   in_e_z,
  input  logic signed [emp_pkg::IN_W-1:0]   in_b_x,
  input  logic signed [emp_pkg::IN_W-1:0]   in_b_y,
  input  logic signed [emp_pkg::IN_W-1:0]   in_b_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [emp_pkg::OUT_W-1:0]         out_energy_density,
  output logic signed [emp_pkg::OUT_W-1:0]  out_flux_x,
  output logic signed [emp_pkg::OUT_W-1:0]  out_flux_y,
  output logic signed [emp_pkg::OUT_W-1:0]  out_flux_z,
  output logic [emp_pkg::OUT_W-1:0]         out_flux_magnitude,
  output logic                              out_saturated
);

  localparam int NCELL = emp_pkg::ROOT_W;
  localparam int OUT_W = emp_pkg::OUT_W;
  localparam logic [emp_pkg::CFG_W-1:0] ONE = emp_pkg::CFG_W'(1) << FRAC_BITS;

  // configuration registers
  logic [emp_pkg::CFG_W-1:0] perm_r;
  logic [emp_pkg::CFG_W-1:0] inv_perm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_r     <= ONE;
      inv_perm_r <= ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        emp_pkg::CFG_PERMITTIVITY: perm_r     <= cfg_wdata;
        emp_pkg::CFG_INV_PERM:     inv_perm_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // chain links, index 0 is the front stage output
  logic           lv  [NCELL+1];
  logic           lr  [NCELL+1];
  emp_pkg::cell_t ld  [NCELL+1];

  emp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .permittivity (perm_r),
    .inv_perm     (inv_perm_r),
    .up_valid     (in_valid),
    .up_ready     (in_ready),
    .e_x          (in_e_x),
    .e_y          (in_e_y),
    .e_z          (in_e_z),
    .b_x          (in_b_x),
    .b_y          (in_b_y),
    .b_z          (in_b_z),
    .dn_valid     (lv[0]),
    .dn_ready     (lr[0]),
    .dn_data      (ld[0])
  );

  // root cells, most significant bit first
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    emp_sqrt_cell #(.BIT(NCELL - 1 - i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (lv[i]),
      .up_ready (lr[i]),
      .up_data  (ld[i]),
      .dn_valid (lv[i+1]),
      .dn_ready (lr[i+1]),
      .dn_data  (ld[i+1])
    );
  end

  // output register
  logic           out_valid_r;
  emp_pkg::side_t res_r;
  logic [OUT_W-1:0] norm_r;
  logic           nsat_r;
  emp_pkg::cell_t last;
  logic           root_over;

  assign last      = ld[NCELL];
  assign lr[NCELL] = !out_valid_r || out_ready;
  assign root_over = last.root[NCELL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (lr[NCELL]) begin
      out_valid_r <= lv[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (lr[NCELL]) begin
      res_r  <= last.side;
      norm_r <= (last.side.huge || root_over) ? emp_pkg::OUT_MAX : last.root[OUT_W-1:0];
      nsat_r <= last.side.huge || root_over;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_energy_density = res_r.energy;
  assign out_flux_x         = res_r.flux_x;
  assign out_flux_y         = res_r.flux_y;
  assign out_flux_z         = res_r.flux_z;
  assign out_flux_magnitude = norm_r;
  assign out_saturated      = res_r.sat | nsat_r;

endmodule

[hw/rtl/emp_checker.sv]
// port level checks for the energy density and poynting vector core
module emp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [emp_pkg::OUT_W-1:0]         out_energy_density,
  input logic signed [emp_pkg::OUT_W-1:0]  out_flux_x,
  input logic [emp_pkg::OUT_W-1:0]         out_flux_magnitude,
  input logic                              out_saturated
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_energy_density)
      && $stable(out_flux_magnitude) && $stable(out_saturated))
    else $error("stalled result changed");

  // input stalls only when every stage is full behind a blocked output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with room in the pipe");

  // norm is never below the flux x component when that component is nonnegative
  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_flux_x[emp_pkg::OUT_W-1] |->
      out_flux_magnitude >= emp_pkg::OUT_W'(out_flux_x))
    else $error("flux norm below flux x component");

endmodule

bind em_energy_poynting_core emp_checker u_emp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_energy_density (out_energy_density),
  .out_flux_x         (out_flux_x),
  .out_flux_magnitude (out_flux_magnitude),
  .out_saturated      (out_saturated)
);
